>>> hw/rtl/pgrw_pkg.sv
package pgrw_pkg;

  localparam int FONT_AW    = 13;
  localparam int FONT_DEPTH = 1 << FONT_AW;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_ADVANCE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VRAM_BASE    = 8'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_FIRST,
    ST_SPILL
  } state_t;

  typedef struct packed {
    logic               wr_en;
    logic [FONT_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [FONT_AW-1:0] rd_addr;
  } font_req_t;

endpackage

>>> hw/rtl/pgrw_if.sv
interface pgrw_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [pgrw_pkg::FONT_AW-1:0] font_index;
  logic [7:0]                  font_byte;
  logic [7:0]                  char_code;
  logic                        new_string;
  logic [15:0]                 start_x;
  logic [9:0]                  start_y;

  modport source (output valid, command, font_index, font_byte, char_code, new_string,
                  start_x, start_y, input ready);
  modport sink (input valid, command, font_index, font_byte, char_code, new_string,
                start_x, start_y, output ready);
endinterface

interface pgrw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] vram_address;
  logic [7:0]  bit_mask;
  logic [7:0]  color_value;
  logic        last_write;

  modport source (output valid, vram_address, bit_mask, color_value, last_write,
                  input ready);
  modport sink (input valid, vram_address, bit_mask, color_value, last_write,
                output ready);
endinterface

interface pgrw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pgrw_pkg::CFG_IDX_W-1:0]  index;
  logic [pgrw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/pgrw_font_ram.sv
module pgrw_font_ram (
  input  logic                clk,
  input  pgrw_pkg::font_req_t req,
  output logic [7:0]          rd_data
);

  logic [7:0] mem [pgrw_pkg::FONT_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/planar_glyph_row_writer.sv
// channel   dir  beat
// in_bus    in   load: font_index, font_byte / draw: char_code, new_string, start_x, start_y
// out_bus   out  vram_address, bit_mask, color_value, last_write
// cfg_bus   in   index, data (registers 0..3, other indexes dropped)
//
// Load beat: written to the font RAM as it is accepted. Draw beat: a setup state, then per
// glyph row a font RAM read state and a first write, plus a spill write when x is not byte aligned.
// Rows are paced by the read and write states and the registered font RAM read.
// Input is taken only in idle; a finished write waits in the output register.
// Output stalls hold the row sequencer. Reset is synchronous; the font RAM is not cleared.
module planar_glyph_row_writer #(
  parameter int MAX_GLYPH_ROWS = 32,
  parameter int BYTES_PER_LINE = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  pgrw_in_if.sink     in_bus,
  pgrw_out_if.source  out_bus,
  pgrw_cfg_if.sink    cfg_bus
);

  localparam int          RowW      = $clog2(MAX_GLYPH_ROWS + 1);
  localparam logic [15:0] LineBytes = 16'(BYTES_PER_LINE);

  pgrw_pkg::state_t state_r, state_nxt;

  logic [5:0]  glyph_height_r;
  logic [15:0] x_advance_r;
  logic [7:0]  draw_color_r;
  logic [15:0] vram_base_r;

  logic [15:0] pen_x_r;
  logic [9:0]  pen_y_r;
  logic [7:0]  char_r;

  logic [RowW-1:0] rows_r;
  logic [RowW-1:0] row_r;
  logic [2:0]      xbit_r;
  logic [15:0]     addr_r;
  logic [15:0]     fbase_r;

  logic        out_valid_r;
  logic [15:0] out_addr_r;
  logic [7:0]  out_mask_r;
  logic [7:0]  out_color_r;
  logic        out_last_r;

  logic            in_acc;
  logic            slot_free;
  logic            spill;
  logic            final_row;
  logic [RowW-1:0] rows_sat;
  logic [25:0]     line_off;
  logic [15:0]     base_addr;
  logic [15:0]     font_sum;
  logic [15:0]     shifted;
  logic [7:0]      font_data;

  logic in_ready;
  logic rd_en;
  logic ld_out;
  logic sel_spill;
  logic row_adv;

  pgrw_pkg::font_req_t font_req;

  assign in_acc    = in_bus.valid && in_ready;
  assign slot_free = !out_valid_r || out_bus.ready;
  assign spill     = (xbit_r != 3'd0);
  assign final_row = (({1'b0, row_r} + 1'b1) == {1'b0, rows_r});
  assign rows_sat  = (32'(glyph_height_r) > MAX_GLYPH_ROWS) ? RowW'(MAX_GLYPH_ROWS)
                                                             : RowW'(glyph_height_r);
  assign line_off  = 26'(pen_y_r) * 26'(LineBytes);
  assign base_addr = vram_base_r + line_off[15:0] + (pen_x_r >> 3);
  assign font_sum  = fbase_r + 16'(row_r);
  // high byte: first write mask, low byte: bits spilled into the next byte
  assign shifted   = {font_data, 8'h00} >> xbit_r;

  assign font_req.wr_en   = in_acc && (in_bus.command == pgrw_pkg::CMD_LOAD);
  assign font_req.wr_addr = in_bus.font_index;
  assign font_req.wr_data = in_bus.font_byte;
  assign font_req.rd_en   = rd_en;
  assign font_req.rd_addr = font_sum[pgrw_pkg::FONT_AW-1:0];

  pgrw_font_ram u_font_ram (
    .clk     (clk),
    .req     (font_req),
    .rd_data (font_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pgrw_pkg::ST_IDLE: begin
        if (in_acc && (in_bus.command == pgrw_pkg::CMD_DRAW)) begin
          state_nxt = pgrw_pkg::ST_SETUP;
        end
      end
      pgrw_pkg::ST_SETUP: begin
        state_nxt = (rows_sat == '0) ? pgrw_pkg::ST_IDLE : pgrw_pkg::ST_READ;
      end
      pgrw_pkg::ST_READ: begin
        state_nxt = pgrw_pkg::ST_FIRST;
      end
      pgrw_pkg::ST_FIRST: begin
        if (slot_free) begin
          if (spill) begin
            state_nxt = pgrw_pkg::ST_SPILL;
          end else begin
            state_nxt = final_row ? pgrw_pkg::ST_IDLE : pgrw_pkg::ST_READ;
          end
        end
      end
      pgrw_pkg::ST_SPILL: begin
        if (slot_free) begin
          state_nxt = final_row ? pgrw_pkg::ST_IDLE : pgrw_pkg::ST_READ;
        end
      end
      default: state_nxt = pgrw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    ld_out    = 1'b0;
    sel_spill = 1'b0;
    row_adv   = 1'b0;
    case (state_r)
      pgrw_pkg::ST_IDLE:  in_ready = 1'b1;
      pgrw_pkg::ST_SETUP: ;
      pgrw_pkg::ST_READ:  rd_en = 1'b1;
      pgrw_pkg::ST_FIRST: begin
        ld_out  = slot_free;
        row_adv = slot_free && !spill;
      end
      pgrw_pkg::ST_SPILL: begin
        ld_out    = slot_free;
        sel_spill = 1'b1;
        row_adv   = slot_free;
      end
      default: ;
    endcase
  end

  assign in_bus.ready  = in_ready;
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= pgrw_pkg::ST_IDLE;
      glyph_height_r <= 6'd14;
      x_advance_r    <= 16'd8;
      draw_color_r   <= 8'd15;
      vram_base_r    <= 16'd0;
      pen_x_r        <= 16'd0;
      pen_y_r        <= 10'd0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          pgrw_pkg::REG_GLYPH_HEIGHT: glyph_height_r <= cfg_bus.data[5:0];
          pgrw_pkg::REG_X_ADVANCE:    x_advance_r    <= cfg_bus.data;
          pgrw_pkg::REG_DRAW_COLOR:   draw_color_r   <= cfg_bus.data[7:0];
          pgrw_pkg::REG_VRAM_BASE:    vram_base_r    <= cfg_bus.data;
          default: ;
        endcase
      end
      if (in_acc && (in_bus.command == pgrw_pkg::CMD_DRAW) && in_bus.new_string) begin
        pen_x_r <= in_bus.start_x;
        pen_y_r <= in_bus.start_y;
      end
      if (state_r == pgrw_pkg::ST_SETUP) begin
        pen_x_r <= pen_x_r + x_advance_r;
      end
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      char_r <= in_bus.char_code;
    end
    if (state_r == pgrw_pkg::ST_SETUP) begin
      rows_r  <= rows_sat;
      row_r   <= '0;
      xbit_r  <= pen_x_r[2:0];
      addr_r  <= base_addr;
      fbase_r <= 16'(glyph_height_r) * 16'(char_r);
    end
    if (row_adv) begin
      row_r  <= row_r + 1'b1;
      addr_r <= addr_r + LineBytes;
    end
    if (ld_out) begin
      out_addr_r  <= sel_spill ? (addr_r + 16'd1) : addr_r;
      out_mask_r  <= sel_spill ? shifted[7:0] : shifted[15:8];
      out_color_r <= draw_color_r;
      out_last_r  <= final_row && (sel_spill || !spill);
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.vram_address = out_addr_r;
  assign out_bus.bit_mask     = out_mask_r;
  assign out_bus.color_value  = out_color_r;
  assign out_bus.last_write   = out_last_r;

`ifndef SYNTHESIS
  a_read_then_first: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == pgrw_pkg::ST_FIRST))
    else $error("font read not followed by first write state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |-> (!out_valid_r || out_bus.ready))
    else $error("output register overwritten before taken");

  a_spill_unaligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgrw_pkg::ST_SPILL) |-> (xbit_r != 3'd0))
    else $error("spill write on byte aligned x");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgrw_pkg::ST_READ) |-> (row_r < rows_r))
    else $error("row counter past glyph height");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_bus.command == pgrw_pkg::CMD_LOAD)) |=> (state_r == pgrw_pkg::ST_IDLE))
    else $error("load beat left idle");
`endif

endmodule

>>> sim/planar_glyph_row_writer_tb.sv
`timescale 1ns / 100ps

module planar_glyph_row_writer_tb;

  localparam int MAX_ROWS      = 32;
  localparam int LINE_BYTES    = 80;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_STRETCH  = 300;

  // indexes the block has no register for
  localparam logic [pgrw_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW = 8'd4;
  localparam logic [pgrw_pkg::CFG_IDX_W-1:0] REG_UNUSED_TOP = 8'hFF;

  typedef struct packed {
    bit                         command;
    bit [pgrw_pkg::FONT_AW-1:0] font_index;
    bit [7:0]                   font_byte;
    bit [7:0]                   char_code;
    bit                         new_string;
    bit [15:0]                  start_x;
    bit [9:0]                   start_y;
  } glyph_cmd_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  mask;
    logic [7:0]  color;
    logic        last;
  } vram_write_t;

  class vram_write_board;
    bit [7:0]    font_rows[pgrw_pkg::FONT_DEPTH];
    bit [15:0]   pen_x;
    bit [9:0]    pen_y;
    bit [5:0]    glyph_height;
    bit [15:0]   x_advance;
    bit [7:0]    draw_color;
    bit [15:0]   vram_base;
    vram_write_t due_writes[$];
    int          errors;

    function new();
      pen_x        = 0;
      pen_y        = 0;
      glyph_height = 14;
      x_advance    = 8;
      draw_color   = 15;
      vram_base    = 0;
      errors       = 0;
    endfunction

    function int outstanding();
      return due_writes.size();
    endfunction

    function void write_reg(bit [pgrw_pkg::CFG_IDX_W-1:0] idx,
                            bit [pgrw_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        pgrw_pkg::REG_GLYPH_HEIGHT: glyph_height = val[5:0];
        pgrw_pkg::REG_X_ADVANCE:    x_advance    = val;
        pgrw_pkg::REG_DRAW_COLOR:   draw_color   = val[7:0];
        pgrw_pkg::REG_VRAM_BASE:    vram_base    = val;
        default: ;
      endcase
    endfunction

    // expands one accepted beat into the writes it must produce
    function void note_command(glyph_cmd_t c);
      int          rows;
      bit [2:0]    shift;
      bit [15:0]   line_addr;
      bit [15:0]   font_base;
      bit [15:0]   font_addr;
      bit [15:0]   row_addr;
      bit [7:0]    bits;
      vram_write_t w;
      if (c.command == pgrw_pkg::CMD_LOAD) begin
        font_rows[c.font_index] = c.font_byte;
        return;
      end
      if (c.new_string) begin
        pen_x = c.start_x;
        pen_y = c.start_y;
      end
      rows      = (glyph_height > MAX_ROWS) ? MAX_ROWS : glyph_height;
      shift     = pen_x[2:0];
      line_addr = 16'(vram_base + pen_y * LINE_BYTES + pen_x[15:3]);
      // stride uses the raw height, not the saturated row count
      font_base = glyph_height * c.char_code;
      for (int r = 0; r < rows; r++) begin
        font_addr = font_base + 16'(r);
        bits      = font_rows[font_addr[pgrw_pkg::FONT_AW-1:0]];
        row_addr  = line_addr + 16'(r * LINE_BYTES);
        w.addr    = row_addr;
        w.mask    = bits >> shift;
        w.color   = draw_color;
        w.last    = (r == rows - 1) && (shift == 0);
        due_writes.push_back(w);
        if (shift != 0) begin
          w.addr = row_addr + 16'd1;
          w.mask = bits << (8 - shift);
          w.last = (r == rows - 1);
          due_writes.push_back(w);
        end
      end
      pen_x = pen_x + x_advance;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_write(vram_write_t got);
      vram_write_t want;
      if (due_writes.size() == 0) begin
        report($sformatf("unexpected write addr %h mask %h color %h last %b",
                         got.addr, got.mask, got.color, got.last));
        return;
      end
      want = due_writes.pop_front();
      if (got.addr !== want.addr)
        report($sformatf("vram_address %h, expected %h", got.addr, want.addr));
      if (got.mask !== want.mask)
        report($sformatf("bit_mask %h, expected %h (addr %h)", got.mask, want.mask, want.addr));
      if (got.color !== want.color)
        report($sformatf("color_value %h, expected %h", got.color, want.color));
      if (got.last !== want.last)
        report($sformatf("last_write %b, expected %b (addr %h)", got.last, want.last,
                         want.addr));
    endtask
  endclass

  logic clk;
  logic rst_n;

  pgrw_in_if  in_ch();
  pgrw_out_if out_ch();
  pgrw_cfg_if cfg_ch();

  planar_glyph_row_writer #(
    .MAX_GLYPH_ROWS(MAX_ROWS),
    .BYTES_PER_LINE(LINE_BYTES)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_ch),
    .out_bus(out_ch),
    .cfg_bus(cfg_ch)
  );

  vram_write_board sb;

  bit          font_written[pgrw_pkg::FONT_DEPTH];
  bit [5:0]    gen_height;
  bit [7:0]    char_pool[$];
  int          items_sent;
  int          send_idle_pct = 31;
  int          recv_idle_pct = 71;
  int          hold_cycles   = 0;
  glyph_cmd_t  mon_cmd;
  vram_write_t mon_wr;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(60_000_000);
    $display("planar_glyph_row_writer_tb failed");
    $finish;
  end

  // receiver: random backpressure, plus long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        mon_cmd.command    = in_ch.command;
        mon_cmd.font_index = in_ch.font_index;
        mon_cmd.font_byte  = in_ch.font_byte;
        mon_cmd.char_code  = in_ch.char_code;
        mon_cmd.new_string = in_ch.new_string;
        mon_cmd.start_x    = in_ch.start_x;
        mon_cmd.start_y    = in_ch.start_y;
        sb.note_command(mon_cmd);
      end
      if (out_ch.valid && out_ch.ready) begin
        mon_wr.addr  = out_ch.vram_address;
        mon_wr.mask  = out_ch.bit_mask;
        mon_wr.color = out_ch.color_value;
        mon_wr.last  = out_ch.last_write;
        sb.check_write(mon_wr);
      end
    end
  end

  function automatic bit [pgrw_pkg::FONT_AW-1:0] glyph_row_index(bit [7:0] ch, int r);
    bit [15:0] a;
    a = gen_height * ch + 16'(r);
    return a[pgrw_pkg::FONT_AW-1:0];
  endfunction

  function automatic int glyph_rows();
    return (gen_height > MAX_ROWS) ? MAX_ROWS : gen_height;
  endfunction

  // called at a falling edge; leaves valid high so beats can go back to back
  task automatic send_cmd(input glyph_cmd_t c);
    if (items_sent < 145) begin
      send_idle_pct = 31;
      recv_idle_pct = 71;
    end else if (items_sent < 290) begin
      send_idle_pct = 71;
      recv_idle_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c.command;
    in_ch.font_index <= c.font_index;
    in_ch.font_byte  <= c.font_byte;
    in_ch.char_code  <= c.char_code;
    in_ch.new_string <= c.new_string;
    in_ch.start_x    <= c.start_x;
    in_ch.start_y    <= c.start_y;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic load_font(input bit [pgrw_pkg::FONT_AW-1:0] idx, input bit [7:0] row_bits);
    glyph_cmd_t c;
    c.command    = pgrw_pkg::CMD_LOAD;
    c.font_index = idx;
    c.font_byte  = row_bits;
    // draw fields ride along and must be ignored
    c.char_code  = 8'($urandom_range(0, 255));
    c.new_string = 1'($urandom_range(0, 1));
    c.start_x    = 16'($urandom_range(0, 65535));
    c.start_y    = 10'($urandom_range(0, 1023));
    font_written[idx] = 1'b1;
    send_cmd(c);
  endtask

  task automatic draw_char(input bit [7:0] ch, input bit fresh, input bit [15:0] x,
                           input bit [9:0] y);
    glyph_cmd_t c;
    c.command    = pgrw_pkg::CMD_DRAW;
    c.font_index = pgrw_pkg::FONT_AW'($urandom_range(0, pgrw_pkg::FONT_DEPTH - 1));
    c.font_byte  = 8'($urandom_range(0, 255));
    c.char_code  = ch;
    c.new_string = fresh;
    c.start_x    = x;
    c.start_y    = y;
    send_cmd(c);
  endtask

  // fills in any glyph row not loaded yet so a draw never reads a blank entry
  task automatic ensure_glyph(input bit [7:0] ch);
    bit [pgrw_pkg::FONT_AW-1:0] idx;
    for (int r = 0; r < glyph_rows(); r++) begin
      idx = glyph_row_index(ch, r);
      if (!font_written[idx]) load_font(idx, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic cfg_beat(input logic [pgrw_pkg::CFG_IDX_W-1:0] idx,
                          input logic [pgrw_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic program_regs(input bit [5:0] gh, input bit [15:0] adv, input bit [7:0] color,
                              input bit [15:0] base);
    bit [15:0] junk;
    junk = 16'($urandom_range(0, 65535));
    // upper bits beyond the glyph height and draw color widths are junk
    cfg_beat(pgrw_pkg::REG_GLYPH_HEIGHT, {junk[15:6], gh});
    cfg_beat(pgrw_pkg::REG_X_ADVANCE, adv);
    cfg_beat(pgrw_pkg::REG_DRAW_COLOR, {junk[7:0], color});
    cfg_beat(pgrw_pkg::REG_VRAM_BASE, base);
    cfg_ch.valid <= 1'b0;
    gen_height = gh;
    char_pool.delete();
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic draw_string();
    int       len;
    bit [7:0] ch;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (char_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
        ch = char_pool[$urandom_range(0, char_pool.size() - 1)];
      end else begin
        ch = 8'($urandom_range(0, 255));
        char_pool.push_back(ch);
      end
      ensure_glyph(ch);
      draw_char(ch, (i == 0) || ($urandom_range(0, 9) == 0), 16'($urandom_range(0, 65535)),
                10'($urandom_range(0, 1023)));
    end
  endtask

  task automatic random_traffic(input int n_items);
    int       start;
    int       pick;
    int       k;
    bit [7:0] ch;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        load_font(pgrw_pkg::FONT_AW'($urandom_range(0, pgrw_pkg::FONT_DEPTH - 1)),
                  8'($urandom_range(0, 255)));
      end else if (pick < 17 && glyph_rows() > 0) begin
        // glyph upload, possibly cut short
        ch = 8'($urandom_range(0, 255));
        k  = $urandom_range(1, glyph_rows());
        for (int r = 0; r < k; r++) begin
          load_font(glyph_row_index(ch, r), 8'($urandom_range(0, 255)));
        end
      end else begin
        draw_string();
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n              = 1'b0;
    items_sent         = 0;
    gen_height         = 14;
    in_ch.valid        = 1'b0;
    in_ch.command      = pgrw_pkg::CMD_LOAD;
    in_ch.font_index   = '0;
    in_ch.font_byte    = '0;
    in_ch.char_code    = '0;
    in_ch.new_string   = 1'b0;
    in_ch.start_x      = '0;
    in_ch.start_y      = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: 14-row glyph for char 1 at rows 14..27
    for (int r = 0; r < 14; r++) begin
      case (r)
        0:       load_font(pgrw_pkg::FONT_AW'(14 + r), 8'hFF);
        1:       load_font(pgrw_pkg::FONT_AW'(14 + r), 8'h80);
        2:       load_font(pgrw_pkg::FONT_AW'(14 + r), 8'h01);
        3:       load_font(pgrw_pkg::FONT_AW'(14 + r), 8'h00);
        default: load_font(pgrw_pkg::FONT_AW'(14 + r), 8'($urandom_range(0, 255)));
      endcase
    end
    draw_char(8'd1, 1'b1, 16'd0, 10'd0);
    draw_char(8'd1, 1'b0, 16'hFFFF, 10'h3FF);   // start fields ignored, pen moves on
    draw_char(8'd1, 1'b1, 16'hFFFF, 10'h3FF);   // widest spill, address wraps
    drain();

    cfg_beat(REG_UNUSED_LOW, 16'h0005);
    cfg_beat(REG_UNUSED_TOP, 16'hFFFF);
    program_regs(6'd0, 16'hFFFF, 8'h00, 16'hFFFF);
    draw_char(8'hFF, 1'b1, 16'd5, 10'd3);       // zero height: no writes, pen still moves
    drain();

    // pen_x is now 4; rows 14..15 already hold char 7 at height 2
    program_regs(6'd2, 16'd0, 8'hFF, 16'hFFFF);
    draw_char(8'd7, 1'b0, 16'd0, 10'd0);
    draw_char(8'd7, 1'b0, 16'hFFFF, 10'h3FF);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: program_regs(6'd1, 16'd0, 8'h00, 16'h0000);
        1: program_regs(6'd32, 16'hFFFF, 8'hFF, 16'hFFFF);
        2: program_regs(6'd63, 16'($urandom), 8'($urandom), 16'($urandom));
        3: program_regs(6'($urandom_range(3, 8)), 16'($urandom_range(0, 24)), 8'($urandom),
                        16'($urandom));
        4: program_regs(6'd0, 16'($urandom), 8'($urandom), 16'($urandom));
        5: program_regs(6'($urandom_range(9, 16)), 16'($urandom), 8'($urandom),
                        16'($urandom));
        6: program_regs(6'($urandom_range(1, 6)), 16'($urandom_range(0, 24)), 8'($urandom),
                        16'($urandom));
        default: program_regs(6'd14, 16'd8, 8'($urandom), 16'($urandom));
      endcase
      if (p == 2) hold_cycles = HOLD_STRETCH;
      if (p == 5) begin
        random_traffic(26);
        drain();
        random_traffic(26);
      end else begin
        random_traffic(52);
      end
    end
    drain();

    if (sb.errors == 0) $display("planar_glyph_row_writer_tb passed");
    else $display("planar_glyph_row_writer_tb failed");
    $finish;
  end

endmodule
